/* rtl/cfr_pkg.sv */
`timescale 1ns / 1ps

package cfr_pkg;

	// Number of payload bytes held for reporting.
	localparam int CaptureBytes = 13;
	localparam int CapIdxW = $clog2(CaptureBytes);

	// Payload bytes shown on the result, byte 12 being the tail byte.
	localparam int ReportedBytes = 13;

	// Depth of the result queue between the front and back ends.
	localparam int QueueDepth = 2;

	// Configuration port widths and register indexes.
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 16;
	localparam logic [CfgIdxW-1:0] RegExpectedType = 2'd0;
	localparam logic [CfgIdxW-1:0] RegMinFieldsLen = 2'd1;

	localparam logic [7:0] ExpectedTypeReset = 8'd4;
	localparam logic [15:0] MinFieldsLenReset = 16'd8;

	// Framing and CRC constants.
	localparam logic [7:0] StartMark = 8'hA5;
	localparam logic [7:0] EndMark = 8'h5A;
	localparam logic [31:0] CrcPoly = 32'hEDB88320;
	localparam logic [31:0] CrcAllOnes = 32'hFFFFFFFF;
	localparam logic [15:0] CrcBytes = 16'd4;

	typedef enum logic [1:0] {
		VERDICT_OK = 2'd0,
		VERDICT_WRONG_TYPE = 2'd1,
		VERDICT_BAD_END = 2'd2,
		VERDICT_BAD_CRC = 2'd3
	} verdict_t;

	typedef logic [CaptureBytes-1:0][7:0] capture_t;

	// One finished frame as the front end hands it to the back end.
	typedef struct packed {
		verdict_t verdict;
		logic [7:0] frame_type;
		logic [15:0] frame_len;
		capture_t captured;
	} frame_rec_t;

	// Configuration register set.
	typedef struct packed {
		logic [7:0] expected_type;
		logic [15:0] min_fields_len;
	} cfg_regs_t;

	// Queue write request from the front end.
	typedef struct packed {
		logic push;
	} queue_wr_t;

	typedef logic [31:0] crc_table_t [256];

	// Builds the reflected CRC-32 byte table at elaboration.
	function automatic crc_table_t crc_gen_table();
		crc_table_t t;
		logic [31:0] c;
		for (int i = 0; i < 256; i++) begin
			c = 32'(i);
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
			end
			t[i] = c;
		end
		return t;
	endfunction

	localparam crc_table_t CrcTable = crc_gen_table();

	// One byte of the reflected CRC-32 update through the table.
	function automatic logic [31:0] crc_update(input logic [31:0] c, input logic [7:0] b);
		return CrcTable[c[7:0] ^ b] ^ {8'h00, c[31:8]};
	endfunction

endpackage

/* rtl/cfr_byte_if.sv */
`timescale 1ns / 1ps

interface cfr_byte_if;
	logic valid;
	logic ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/cfr_result_if.sv */
`timescale 1ns / 1ps

interface cfr_result_if;
	logic valid;
	logic ready;
	logic [1:0] verdict;
	logic [7:0] frame_type;
	logic [15:0] frame_len;
	logic fields_valid;
	logic [31:0] word0;
	logic [31:0] word1;
	logic [31:0] word2;
	logic [7:0] tail_byte;

	modport source (
		output valid, output verdict, output frame_type, output frame_len,
		output fields_valid, output word0, output word1, output word2, output tail_byte,
		input ready
	);
	modport sink (
		input valid, input verdict, input frame_type, input frame_len,
		input fields_valid, input word0, input word1, input word2, input tail_byte,
		output ready
	);
endinterface

/* rtl/cfr_cfg_if.sv */
`timescale 1ns / 1ps

interface cfr_cfg_if;
	logic valid;
	logic ready;
	logic [cfr_pkg::CfgIdxW-1:0] index;
	logic [cfr_pkg::CfgDataW-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/cfr_front.sv */
`timescale 1ns / 1ps

module cfr_front (
	input logic clk,
	input logic arst_n,
	cfr_byte_if.sink rx,
	input logic [7:0] expected_type,
	input logic queue_full,
	output cfr_pkg::queue_wr_t qwr,
	output cfr_pkg::frame_rec_t rec
);

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_TYPE,
		ST_LEN_LO,
		ST_LEN_HI,
		ST_PAYLOAD,
		ST_CRC,
		ST_END
	} state_t;

	state_t state_q;
	logic [7:0] type_q;
	logic [15:0] len_q;
	logic [15:0] count_q;
	logic [31:0] crc_q;
	logic [31:0] rcrc_q;
	logic skip_q;
	cfr_pkg::capture_t cap_q;

	logic accept;
	logic [7:0] b;
	logic [15:0] count_inc;
	logic [31:0] crc_next;
	cfr_pkg::verdict_t verdict;

	// A request is taken whenever the result queue has room.
	assign rx.ready = !queue_full;
	assign accept = rx.valid && rx.ready;
	assign b = rx.rx_byte;
	assign count_inc = count_q + 16'd1;
	assign crc_next = cfr_pkg::crc_update(crc_q, b);

	// Verdict of the frame on its end byte.
	always_comb begin
		if (skip_q) begin
			verdict = cfr_pkg::VERDICT_WRONG_TYPE;
		end else if (b != cfr_pkg::EndMark) begin
			verdict = cfr_pkg::VERDICT_BAD_END;
		end else if ((crc_q ^ cfr_pkg::CrcAllOnes) != rcrc_q) begin
			verdict = cfr_pkg::VERDICT_BAD_CRC;
		end else begin
			verdict = cfr_pkg::VERDICT_OK;
		end
	end

	assign qwr.push = accept && (state_q == ST_END);
	assign rec.verdict = verdict;
	assign rec.frame_type = type_q;
	assign rec.frame_len = len_q;
	assign rec.captured = cap_q;

	// Frame parser, one byte per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			type_q <= 8'h00;
			len_q <= 16'h0000;
			count_q <= 16'h0000;
			crc_q <= cfr_pkg::CrcAllOnes;
			rcrc_q <= 32'h0;
			skip_q <= 1'b0;
		end else if (accept) begin
			case (state_q)
				ST_HUNT: begin
					if (b == cfr_pkg::StartMark) begin
						crc_q <= cfr_pkg::crc_update(cfr_pkg::CrcAllOnes, b);
						rcrc_q <= 32'h0;
						count_q <= 16'h0000;
						skip_q <= 1'b0;
						state_q <= ST_TYPE;
					end
				end
				ST_TYPE: begin
					type_q <= b;
					crc_q <= crc_next;
					state_q <= ST_LEN_LO;
				end
				ST_LEN_LO: begin
					len_q <= {8'h00, b};
					crc_q <= crc_next;
					state_q <= ST_LEN_HI;
				end
				ST_LEN_HI: begin
					len_q <= {b, len_q[7:0]};
					crc_q <= crc_next;
					skip_q <= (type_q != expected_type);
					count_q <= 16'h0000;
					state_q <= ({b, len_q[7:0]} == 16'h0000) ? ST_CRC : ST_PAYLOAD;
				end
				ST_PAYLOAD: begin
					if (!skip_q) begin
						crc_q <= crc_next;
					end
					if (count_inc >= len_q) begin
						count_q <= 16'h0000;
						state_q <= ST_CRC;
					end else begin
						count_q <= count_inc;
					end
				end
				ST_CRC: begin
					rcrc_q <= rcrc_q | ({24'h0, b} << {count_q[1:0], 3'b000});
					count_q <= count_inc;
					if (count_inc >= cfr_pkg::CrcBytes) begin
						state_q <= ST_END;
					end
				end
				ST_END: begin
					skip_q <= 1'b0;
					state_q <= ST_HUNT;
				end
				default: begin
					state_q <= ST_HUNT;
				end
			endcase
		end
	end

	// Payload capture store, written only while it is in range.
	always_ff @(posedge clk) begin
		if (accept && (state_q == ST_PAYLOAD) && !skip_q &&
		    (count_q < 16'(cfr_pkg::CaptureBytes))) begin
			cap_q[count_q[cfr_pkg::CapIdxW-1:0]] <= b;
		end
	end

endmodule

/* rtl/cfr_queue.sv */
`timescale 1ns / 1ps

module cfr_queue (
	input logic clk,
	input logic arst_n,
	input cfr_pkg::queue_wr_t qwr,
	input cfr_pkg::frame_rec_t wr_rec,
	output logic full,
	output logic not_empty,
	input logic pop,
	output cfr_pkg::frame_rec_t rd_rec
);

	localparam int PtrW = (cfr_pkg::QueueDepth > 1) ? $clog2(cfr_pkg::QueueDepth) : 1;
	localparam int CntW = $clog2(cfr_pkg::QueueDepth + 1);

	cfr_pkg::frame_rec_t mem_q [cfr_pkg::QueueDepth];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [CntW-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full = (cnt_q == CntW'(cfr_pkg::QueueDepth));
	assign not_empty = (cnt_q != '0);
	assign do_push = qwr.push;
	assign do_pop = pop && not_empty;
	assign rd_rec = mem_q[rptr_q];

	// Pointer wrap at the queue depth.
	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(cfr_pkg::QueueDepth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= ptr_inc(wptr_q);
			end
			if (do_pop) begin
				rptr_q <= ptr_inc(rptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wr_rec;
		end
	end

endmodule

/* rtl/cfr_back.sv */
`timescale 1ns / 1ps

module cfr_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input cfr_pkg::frame_rec_t head,
	input logic [15:0] min_fields_len,
	output logic pop,
	cfr_result_if.source result
);

	logic valid_q;
	logic [1:0] verdict_q;
	logic [7:0] frame_type_q;
	logic [15:0] frame_len_q;
	logic fields_valid_q;
	logic [cfr_pkg::ReportedBytes-1:0][7:0] bytes_q;

	logic fv;
	logic [cfr_pkg::ReportedBytes-1:0][7:0] rep;

	assign fv = (head.verdict == cfr_pkg::VERDICT_OK) && (head.frame_len >= min_fields_len);

	// Reported bytes: zero past the length, past the store, or when fields are not valid.
	for (genvar g = 0; g < cfr_pkg::ReportedBytes; g++) begin : g_rep
		if (g < cfr_pkg::CaptureBytes) begin : g_cap
			assign rep[g] = (fv && (head.frame_len > 16'(g))) ? head.captured[g] : 8'h00;
		end else begin : g_zero
			assign rep[g] = 8'h00;
		end
	end

	// Output register is loaded when it is empty or being drained.
	assign pop = head_valid && (!valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || result.ready) begin
			valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= head.verdict;
			frame_type_q <= head.frame_type;
			frame_len_q <= head.frame_len;
			fields_valid_q <= fv;
			bytes_q <= rep;
		end
	end

	assign result.valid = valid_q;
	assign result.verdict = verdict_q;
	assign result.frame_type = frame_type_q;
	assign result.frame_len = frame_len_q;
	assign result.fields_valid = fields_valid_q;
	assign result.word0 = {bytes_q[3], bytes_q[2], bytes_q[1], bytes_q[0]};
	assign result.word1 = {bytes_q[7], bytes_q[6], bytes_q[5], bytes_q[4]};
	assign result.word2 = {bytes_q[11], bytes_q[10], bytes_q[9], bytes_q[8]};
	assign result.tail_byte = bytes_q[cfr_pkg::ReportedBytes-1];

endmodule

/* rtl/crc32_frame_receiver.sv */
`timescale 1ns / 1ps

// Deframer for a serial byte stream: hunts for the 0xA5 start marker, reads type,
// little-endian length, payload, little-endian CRC-32 and end byte, and emits one
// result request per frame on its end byte. It takes one byte every cycle; the byte
// input stalls only while the two-entry result queue is full. A frame's result goes
// through the result queue and then the output register. The CRC-32 advances one
// byte per cycle while bytes are accepted, through a table lookup.
// Configuration writes are accepted at any time and should be made between frames.
module crc32_frame_receiver (
	input logic clk,
	input logic arst_n,
	cfr_byte_if.sink rx,
	cfr_cfg_if.sink cfg,
	cfr_result_if.source result
);

	cfr_pkg::cfg_regs_t cfg_q;
	cfr_pkg::queue_wr_t qwr;
	cfr_pkg::frame_rec_t wr_rec;
	cfr_pkg::frame_rec_t rd_rec;
	logic queue_full;
	logic queue_not_empty;
	logic pop;

	// Configuration registers; unknown indexes are ignored.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_type <= cfr_pkg::ExpectedTypeReset;
			cfg_q.min_fields_len <= cfr_pkg::MinFieldsLenReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				cfr_pkg::RegExpectedType: cfg_q.expected_type <= cfg.data[7:0];
				cfr_pkg::RegMinFieldsLen: cfg_q.min_fields_len <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

	cfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.expected_type(cfg_q.expected_type),
		.queue_full(queue_full),
		.qwr(qwr),
		.rec(wr_rec)
	);

	cfr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.qwr(qwr),
		.wr_rec(wr_rec),
		.full(queue_full),
		.not_empty(queue_not_empty),
		.pop(pop),
		.rd_rec(rd_rec)
	);

	cfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(queue_not_empty),
		.head(rd_rec),
		.min_fields_len(cfg_q.min_fields_len),
		.pop(pop),
		.result(result)
	);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import cfr_pkg::*;

	localparam int CycleLimit = 1_000_000;
	localparam int SettleCycles = 6;

	// Indexes outside the register map; the block must ignore writes to them.
	localparam logic [CfgIdxW-1:0] RegUnusedLo = 2'd2;
	localparam logic [CfgIdxW-1:0] RegUnusedHi = 2'd3;

	typedef logic [7:0] byte_q_t[$];

	typedef enum logic [2:0] {
		RX_HUNT,
		RX_TYPE,
		RX_LEN_LO,
		RX_LEN_HI,
		RX_PAYLOAD,
		RX_CRC,
		RX_END
	} deframe_phase_t;

	typedef enum int {
		FRAME_GOOD,
		FRAME_BAD_CRC,
		FRAME_BAD_END,
		FRAME_WRONG_TYPE
	} frame_kind_t;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	typedef struct {
		verdict_t verdict;
		logic [7:0] frame_type;
		logic [15:0] frame_len;
		logic fields_valid;
		logic [31:0] word0;
		logic [31:0] word1;
		logic [31:0] word2;
		logic [7:0] tail_byte;
	} frame_report_t;

	logic clk = 1'b0;
	logic arst_n;

	cfr_byte_if rx_if ();
	cfr_cfg_if cfg_if ();
	cfr_result_if res_if ();

	crc32_frame_receiver dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.cfg(cfg_if),
		.result(res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Register copies as the block should hold them.
	logic [7:0] exp_type = ExpectedTypeReset;
	logic [15:0] min_len = MinFieldsLenReset;

	// Deframer state of the prediction.
	deframe_phase_t rx_phase = RX_HUNT;
	logic [7:0] seen_type = '0;
	logic [15:0] seen_len = '0;
	int byte_cnt = 0;
	logic [31:0] run_crc = CrcAllOnes;
	logic [31:0] rcv_crc = '0;
	logic [7:0] cap_bytes [CaptureBytes];
	logic skip_tail = 1'b0;

	frame_report_t awaited_reports[$];
	logic [7:0] link_bytes[$];

	// Traffic shaping and bookkeeping.
	logic hold_rx = 1'b0;
	logic bursty = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;
	int gap_left = 0;
	int burst_left = 0;
	int stall_tick = 0;
	logic rx_next_valid;
	int bytes_queued = 0;
	int bytes_taken = 0;
	int frames_queued = 0;
	int mismatches = 0;
	int verdict_seen [4] = '{0, 0, 0, 0};
	int cycles = 0;
	frame_report_t report_due;

	initial begin
		foreach (cap_bytes[i]) cap_bytes[i] = '0;
	end

	// Bitwise reflected CRC-32 update over one byte.
	function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CrcPoly ^ (r >> 1)) : (r >> 1);
		end
		return r;
	endfunction

	// A payload byte as reported: zero past the length or past the capture window.
	function automatic logic [7:0] shown_byte(input int i);
		if (i >= CaptureBytes || i >= int'(seen_len)) return 8'h00;
		return cap_bytes[i];
	endfunction

	function automatic logic [31:0] shown_word(input int base);
		return {shown_byte(base + 3), shown_byte(base + 2), shown_byte(base + 1),
			shown_byte(base)};
	endfunction

	// Advances the predicted deframer by one accepted byte; the end byte yields a report.
	task automatic deframe_byte(input logic [7:0] b);
		frame_report_t r;
		case (rx_phase)
			RX_HUNT: begin
				if (b == StartMark) begin
					run_crc = crc32_byte(CrcAllOnes, b);
					rcv_crc = '0;
					byte_cnt = 0;
					skip_tail = 1'b0;
					rx_phase = RX_TYPE;
				end
			end
			RX_TYPE: begin
				seen_type = b;
				run_crc = crc32_byte(run_crc, b);
				rx_phase = RX_LEN_LO;
			end
			RX_LEN_LO: begin
				seen_len = {8'h00, b};
				run_crc = crc32_byte(run_crc, b);
				rx_phase = RX_LEN_HI;
			end
			RX_LEN_HI: begin
				seen_len[15:8] = b;
				run_crc = crc32_byte(run_crc, b);
				// The type check uses the register value at this byte.
				skip_tail = (seen_type != exp_type);
				byte_cnt = 0;
				rx_phase = (seen_len == 16'd0) ? RX_CRC : RX_PAYLOAD;
			end
			RX_PAYLOAD: begin
				if (!skip_tail) begin
					run_crc = crc32_byte(run_crc, b);
					if (byte_cnt < CaptureBytes) cap_bytes[byte_cnt] = b;
				end
				byte_cnt++;
				if (byte_cnt >= int'(seen_len)) begin
					byte_cnt = 0;
					rx_phase = RX_CRC;
				end
			end
			RX_CRC: begin
				rcv_crc = rcv_crc | ({24'h0, b} << (8 * (byte_cnt % 4)));
				byte_cnt++;
				if (byte_cnt >= 4) rx_phase = RX_END;
			end
			RX_END: begin
				if (skip_tail) r.verdict = VERDICT_WRONG_TYPE;
				else if (b != EndMark) r.verdict = VERDICT_BAD_END;
				else if ((run_crc ^ CrcAllOnes) != rcv_crc) r.verdict = VERDICT_BAD_CRC;
				else r.verdict = VERDICT_OK;
				r.frame_type = seen_type;
				r.frame_len = seen_len;
				r.fields_valid = (r.verdict == VERDICT_OK) && (seen_len >= min_len);
				r.word0 = r.fields_valid ? shown_word(0) : '0;
				r.word1 = r.fields_valid ? shown_word(4) : '0;
				r.word2 = r.fields_valid ? shown_word(8) : '0;
				r.tail_byte = r.fields_valid ? shown_byte(ReportedBytes - 1) : '0;
				awaited_reports.push_back(r);
				skip_tail = 1'b0;
				rx_phase = RX_HUNT;
			end
			default: rx_phase = RX_HUNT;
		endcase
	endtask

	function automatic void queue_byte(input logic [7:0] b);
		link_bytes.push_back(b);
		bytes_queued++;
	endfunction

	// Queues a whole frame around the given payload, spoiled as the kind asks.
	task automatic queue_frame(input logic [7:0] ftype, input frame_kind_t kind,
			input byte_q_t body);
		logic [31:0] crc;
		logic [15:0] len;
		logic [7:0] hdr [4];
		logic [7:0] end_byte;
		len = 16'(body.size());
		hdr[0] = StartMark;
		hdr[1] = ftype;
		hdr[2] = len[7:0];
		hdr[3] = len[15:8];
		crc = CrcAllOnes;
		foreach (hdr[i]) begin
			crc = crc32_byte(crc, hdr[i]);
			queue_byte(hdr[i]);
		end
		foreach (body[i]) begin
			crc = crc32_byte(crc, body[i]);
			queue_byte(body[i]);
		end
		crc = crc ^ CrcAllOnes;
		end_byte = EndMark;
		case (kind)
			FRAME_BAD_CRC: crc = crc ^ (32'd1 << $urandom_range(0, 31));
			FRAME_BAD_END: begin
				do end_byte = 8'($urandom_range(0, 255)); while (end_byte == EndMark);
			end
			FRAME_WRONG_TYPE: begin
				// The tail of a skipped frame is arbitrary.
				crc = $urandom;
				end_byte = 8'($urandom_range(0, 255));
			end
			default: ;
		endcase
		for (int i = 0; i < 4; i++) queue_byte(crc[8 * i +: 8]);
		queue_byte(end_byte);
		frames_queued++;
	endtask

	// Mostly well-formed frames with random content, some spoiled, some line noise between.
	task automatic queue_random_traffic(input int n_bytes);
		int start;
		int pick;
		int len;
		logic [7:0] ftype;
		logic [7:0] noise;
		frame_kind_t kind;
		byte_q_t body;
		start = bytes_queued;
		while (bytes_queued - start < n_bytes) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 4)) begin
					do noise = 8'($urandom_range(0, 255)); while (noise == StartMark);
					queue_byte(noise);
				end
			end
			pick = $urandom_range(0, 9);
			kind = (pick == 0) ? FRAME_BAD_CRC : (pick == 1) ? FRAME_BAD_END :
				(pick == 2) ? FRAME_WRONG_TYPE : FRAME_GOOD;
			ftype = exp_type;
			if (kind == FRAME_WRONG_TYPE) begin
				do ftype = 8'($urandom_range(0, 255)); while (ftype == exp_type);
			end
			pick = $urandom_range(0, 19);
			len = (pick < 14) ? $urandom_range(0, 16) :
				(pick < 19) ? $urandom_range(17, 40) : $urandom_range(41, 200);
			body = {};
			repeat (len) body.push_back(8'($urandom_range(0, 255)));
			queue_frame(ftype, kind, body);
		end
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
		if (idx == RegExpectedType) exp_type = value[7:0];
		else if (idx == RegMinFieldsLen) min_len = value;
	endtask

	// Waits until every queued byte is taken and every report has come back.
	task automatic wait_quiet();
		do @(negedge clk);
		while (link_bytes.size() != 0 || rx_if.valid || awaited_reports.size() != 0);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic compare_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", fname, want, got);
			mismatches++;
		end
	endtask

	// Byte sender: bursts of random length with random gaps while bursty is set.
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= '0;
		end else begin
			if (rx_if.valid && rx_if.ready) begin
				deframe_byte(rx_if.rx_byte);
				bytes_taken++;
			end
			if (!rx_if.valid || rx_if.ready) begin
				rx_next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (!hold_rx && link_bytes.size() != 0) begin
					rx_next_valid = 1'b1;
					rx_if.rx_byte <= link_bytes.pop_front();
					if (bursty) begin
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(0, 40);
							gap_left = $urandom_range(1, 8);
						end
					end
				end
				rx_if.valid <= rx_next_valid;
			end
		end
	end

	// Report receiver: checks each request against the oldest prediction.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (awaited_reports.size() == 0) begin
					$error("frame report with no frame pending, verdict %0d", res_if.verdict);
					mismatches++;
				end else begin
					report_due = awaited_reports.pop_front();
					compare_field("verdict", 32'(report_due.verdict), 32'(res_if.verdict));
					compare_field("frame_type", 32'(report_due.frame_type),
						32'(res_if.frame_type));
					compare_field("frame_len", 32'(report_due.frame_len),
						32'(res_if.frame_len));
					compare_field("fields_valid", 32'(report_due.fields_valid),
						32'(res_if.fields_valid));
					compare_field("word0", report_due.word0, res_if.word0);
					compare_field("word1", report_due.word1, res_if.word1);
					compare_field("word2", report_due.word2, res_if.word2);
					compare_field("tail_byte", 32'(report_due.tail_byte), 32'(res_if.tail_byte));
					verdict_seen[res_if.verdict]++;
				end
			end
			stall_tick++;
			case (stall_mode)
				STALL_RANDOM: res_if.ready <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: res_if.ready <= ((stall_tick % 11) >= 4);
				STALL_HEAVY: res_if.ready <= ($urandom_range(0, 9) < 3);
				default: res_if.ready <= 1'b1;
			endcase
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("Timed out after %0d cycles with %0d reports outstanding.",
				cycles, awaited_reports.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		byte_q_t body;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		res_if.ready = 1'b0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames under the reset register values.
		queue_byte(8'h00);
		queue_byte(8'hFF);
		body = {};
		queue_frame(ExpectedTypeReset, FRAME_GOOD, body);
		// Full capture window with markers and extreme values inside the payload.
		body = {};
		body.push_back(8'h00);
		body.push_back(8'hFF);
		body.push_back(StartMark);
		body.push_back(EndMark);
		for (int i = 0; i < 9; i++) body.push_back(8'(i * 29 + 1));
		queue_frame(ExpectedTypeReset, FRAME_GOOD, body);
		// Length equal to the minimum, then one short of it.
		body = {};
		repeat (8) body.push_back(8'($urandom_range(0, 255)));
		queue_frame(ExpectedTypeReset, FRAME_GOOD, body);
		void'(body.pop_back());
		queue_frame(ExpectedTypeReset, FRAME_GOOD, body);
		// Payload longer than the capture window.
		body = {};
		repeat (14) body.push_back(8'($urandom_range(0, 255)));
		queue_frame(ExpectedTypeReset, FRAME_GOOD, body);
		body = {};
		body.push_back(8'h5A);
		body.push_back(8'hA5);
		queue_frame(8'h03, FRAME_WRONG_TYPE, body);
		void'(body.pop_back());
		queue_frame(ExpectedTypeReset, FRAME_BAD_END, body);
		body = {};
		queue_frame(ExpectedTypeReset, FRAME_BAD_CRC, body);
		wait_quiet();

		// Type zero (upper data bits must be dropped), no length minimum.
		write_reg(RegExpectedType, 16'hFF00);
		write_reg(RegMinFieldsLen, 16'h0000);
		bursty = 1'b1;
		stall_mode = STALL_RANDOM;
		queue_random_traffic(350);
		// Hold the sender once until every report is back.
		do @(negedge clk); while (link_bytes.size() > 175);
		hold_rx = 1'b1;
		do @(negedge clk); while (rx_if.valid || awaited_reports.size() != 0);
		repeat (SettleCycles) @(negedge clk);
		hold_rx = 1'b0;
		wait_quiet();

		// Type 0xFF and the largest minimum, which none of these frames meets.
		write_reg(RegExpectedType, 16'h00FF);
		write_reg(RegMinFieldsLen, 16'hFFFF);
		stall_mode = STALL_PERIODIC;
		queue_random_traffic(250);
		wait_quiet();

		// Writes to unmapped indexes, then a random type with the minimum at the window size.
		write_reg(RegUnusedLo, 16'($urandom_range(0, 65535)));
		write_reg(RegUnusedHi, 16'($urandom_range(0, 65535)));
		write_reg(RegExpectedType, 16'($urandom_range(0, 65535)));
		write_reg(RegMinFieldsLen, 16'(CaptureBytes));
		bursty = 1'b1;
		stall_mode = STALL_HEAVY;
		queue_random_traffic(350);
		wait_quiet();

		// Minimum of one, type equal to the end marker value.
		write_reg(RegMinFieldsLen, 16'h0001);
		write_reg(RegExpectedType, 16'(EndMark));
		bursty = 1'b0;
		stall_mode = STALL_RANDOM;
		queue_random_traffic(350);
		wait_quiet();

		$display("Sent %0d frames in %0d bytes over five register settings.",
			frames_queued, bytes_taken);
		$display("Reports: %0d ok, %0d wrong type, %0d bad end marker, %0d bad crc.",
			verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3]);
		if (mismatches == 0 && awaited_reports.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
